// ===== design/gwbc_pkg.sv =====
// Shared types, constants and register map of the gyro warm-up bias calibrator.
package gwbc_pkg;

	localparam int NUM_AXES_DEF    = 3;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int TEMP_BITS  = 11;
	localparam int WIN_BITS   = 8;
	localparam int CHK_BITS   = 8;
	localparam int CNT_BITS   = 16;
	localparam int RATE_BITS  = 12;
	localparam int CORR_BITS  = 25;
	localparam int ACC_BITS   = 38;
	localparam int DIVISOR_W  = CNT_BITS + 1;
	localparam int MAX_AXES   = 3;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_TARGET_TEMP   = 3'd0;
	localparam logic [2:0] REG_TEMP_WINDOW   = 3'd1;
	localparam logic [2:0] REG_SETTLE_CHECKS = 3'd2;
	localparam logic [2:0] REG_CHECK_DIVIDER = 3'd3;
	localparam logic [2:0] REG_CALIB_SAMPLES = 3'd4;
	localparam logic [2:0] REG_SAMPLE_RATE   = 3'd5;

	localparam logic [TEMP_BITS-1:0] RST_TARGET_TEMP   = 11'd320;
	localparam logic [WIN_BITS-1:0]  RST_TEMP_WINDOW   = 8'd4;
	localparam logic [CHK_BITS-1:0]  RST_SETTLE_CHECKS = 8'd50;
	localparam logic [CHK_BITS-1:0]  RST_CHECK_DIVIDER = 8'd10;
	localparam logic [CNT_BITS-1:0]  RST_CALIB_SAMPLES = 16'd1000;
	localparam logic [RATE_BITS-1:0] RST_SAMPLE_RATE   = 12'd1000;

	typedef enum logic [1:0] {
		MODE_WARMUP,
		MODE_CALIB,
		MODE_RUN
	} mode_t;

	typedef struct packed {
		logic signed [TEMP_BITS-1:0] target_temp;
		logic [WIN_BITS-1:0]         temp_window;
		logic [CHK_BITS-1:0]         settle_checks;
		logic [CHK_BITS-1:0]         check_divider;
		logic [CNT_BITS-1:0]         calib_samples;
		logic [RATE_BITS-1:0]        sample_rate;
	} cfg_t;

	typedef struct packed {
		logic sub_en;
		logic mul_en;
		logic acc_en;
		logic run;
		logic bias_we;
	} axis_ctl_t;

endpackage

// ===== design/gwbc_regs.sv =====
// APB configuration registers of the gyro warm-up bias calibrator.
module gwbc_regs import gwbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_temp   <= RST_TARGET_TEMP;
			cfg_q.temp_window   <= RST_TEMP_WINDOW;
			cfg_q.settle_checks <= RST_SETTLE_CHECKS;
			cfg_q.check_divider <= RST_CHECK_DIVIDER;
			cfg_q.calib_samples <= RST_CALIB_SAMPLES;
			cfg_q.sample_rate   <= RST_SAMPLE_RATE;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TARGET_TEMP:   cfg_q.target_temp   <= pwdata[TEMP_BITS-1:0];
				REG_TEMP_WINDOW:   cfg_q.temp_window   <= pwdata[WIN_BITS-1:0];
				REG_SETTLE_CHECKS: cfg_q.settle_checks <= pwdata[CHK_BITS-1:0];
				REG_CHECK_DIVIDER: cfg_q.check_divider <= pwdata[CHK_BITS-1:0];
				REG_CALIB_SAMPLES: cfg_q.calib_samples <= pwdata[CNT_BITS-1:0];
				REG_SAMPLE_RATE:   cfg_q.sample_rate   <= pwdata[RATE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TARGET_TEMP: prdata = {{(DATA_W-TEMP_BITS){cfg_q.target_temp[TEMP_BITS-1]}},
				cfg_q.target_temp};
			REG_TEMP_WINDOW:   prdata = {{(DATA_W-WIN_BITS){1'b0}}, cfg_q.temp_window};
			REG_SETTLE_CHECKS: prdata = {{(DATA_W-CHK_BITS){1'b0}}, cfg_q.settle_checks};
			REG_CHECK_DIVIDER: prdata = {{(DATA_W-CHK_BITS){1'b0}}, cfg_q.check_divider};
			REG_CALIB_SAMPLES: prdata = {{(DATA_W-CNT_BITS){1'b0}}, cfg_q.calib_samples};
			REG_SAMPLE_RATE:   prdata = {{(DATA_W-RATE_BITS){1'b0}}, cfg_q.sample_rate};
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== design/gwbc_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module gwbc_div #(
	parameter int N_W = 42,
	parameter int D_W = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [N_W-1:0] dividend,
	input  logic [D_W-1:0]        divisor,
	output logic                  done,
	output logic signed [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   work_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dvs_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     trial_sub;
	logic             fits;

	// work_q shifts the dividend magnitude out at the top and the quotient in at the bottom
	assign trial     = {rem_q, work_q[N_W-1]};
	assign fits      = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			work_q <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
				neg_q  <= dividend[N_W-1];
				work_q <= dividend[N_W-1] ? N_W'(-dividend) : dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				work_q <= {work_q[N_W-2:0], fits};
				rem_q  <= fits ? trial_sub[D_W-1:0] : trial[D_W-1:0];
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? N_W'(-work_q) : work_q;

endmodule

// ===== design/gwbc_axis.sv =====
// Shared per-axis datapath: bias correction, rate difference, acceleration multiply, sums.
module gwbc_axis import gwbc_pkg::*; #(
	parameter int NUM_AXES    = NUM_AXES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IDX_W      = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1,
	localparam int SUM_W      = SAMPLE_BITS + 18,
	localparam int B_W        = SAMPLE_BITS + 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  axis_ctl_t                    ctl,
	input  logic [IDX_W-1:0]             idx,
	input  logic signed [SAMPLE_BITS-1:0] raw,
	input  logic [RATE_BITS-1:0]         sample_rate,
	input  logic signed [B_W-1:0]        bias_wr,
	output logic signed [SUM_W-1:0]      sum_rd,
	output logic signed [CORR_BITS-1:0]  corr [NUM_AXES],
	output logic signed [ACC_BITS-1:0]   accel [NUM_AXES]
);

	localparam int C_W = (SAMPLE_BITS + 9 > CORR_BITS) ? SAMPLE_BITS + 9 : CORR_BITS;
	localparam int D_W = C_W + 1;
	localparam int P_W = D_W + RATE_BITS + 1;

	logic signed [C_W-1:0]       prev_q [NUM_AXES];
	logic signed [SUM_W-1:0]     sum_q [NUM_AXES];
	logic signed [B_W-1:0]       bias_q [NUM_AXES];
	logic signed [D_W-1:0]       diff_q;
	logic signed [CORR_BITS-1:0] corr_q [NUM_AXES];
	logic signed [ACC_BITS-1:0]  acc_q [NUM_AXES];

	logic signed [C_W-1:0]       raw_sh;
	logic signed [C_W-1:0]       bias_ext;
	logic signed [C_W-1:0]       c_val;
	logic signed [D_W-1:0]       diff_val;
	logic signed [P_W-1:0]       prod;
	logic signed [SUM_W-1:0]     raw_sum_ext;

	assign raw_sh      = {{(C_W-SAMPLE_BITS-8){raw[SAMPLE_BITS-1]}}, raw, 8'd0};
	assign bias_ext    = {{(C_W-B_W){bias_q[idx][B_W-1]}}, bias_q[idx]};
	assign c_val       = ctl.run ? raw_sh - bias_ext : raw_sh;
	assign diff_val    = {c_val[C_W-1], c_val} - {prev_q[idx][C_W-1], prev_q[idx]};
	assign prod        = diff_q * $signed({1'b0, sample_rate});
	assign raw_sum_ext = {{(SUM_W-SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw};
	assign sum_rd      = sum_q[idx];

	// calibration and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prev_q[a] <= '0;
				sum_q[a]  <= '0;
				bias_q[a] <= '0;
			end
		end else begin
			if (ctl.sub_en && ctl.run)
				prev_q[idx] <= c_val;
			if (ctl.sub_en && ctl.acc_en)
				sum_q[idx] <= sum_q[idx] + raw_sum_ext;
			if (ctl.bias_we)
				bias_q[idx] <= bias_wr;
		end
	end

	// per-item results
	always_ff @(posedge clk) begin
		if (ctl.sub_en) begin
			corr_q[idx] <= c_val[CORR_BITS-1:0];
			diff_q      <= diff_val;
		end
		if (ctl.mul_en)
			acc_q[idx] <= ctl.run ? prod[ACC_BITS-1:0] : '0;
	end

	assign corr  = corr_q;
	assign accel = acc_q;

endmodule

// ===== design/gyro_warmup_bias_calibrator.sv =====
// Gyro warm-up bias calibrator: top level with the item sequencer.
// After a sample transfer each axis passes S_SUB then S_MUL, then S_CHECK and S_DONE follow.
// The sample that ends calibration also runs the bias divider per axis in S_DIV_START and S_DIV_WAIT.
// result_valid rises when S_DONE finds the output free. No new sample is taken until the
// sequencer is back in S_IDLE (sample_stall); the shared axis datapath handles the axes in turn.
// A finished result waits in the output register while the next sample is taken.
// Reset: asynchronous, active low; warm-up phase, counters, sums, biases and registers at defaults.
module gyro_warmup_bias_calibrator import gwbc_pkg::*; #(
	parameter int NUM_AXES    = NUM_AXES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] rate_x,
	input  logic signed [SAMPLE_BITS-1:0] rate_y,
	input  logic signed [SAMPLE_BITS-1:0] rate_z,
	input  logic signed [TEMP_BITS-1:0]   temperature,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    phase,
	output logic                          ready_res,
	output logic signed [CORR_BITS-1:0]   corr_x,
	output logic signed [CORR_BITS-1:0]   corr_y,
	output logic signed [CORR_BITS-1:0]   corr_z,
	output logic signed [ACC_BITS-1:0]    accel_x,
	output logic signed [ACC_BITS-1:0]    accel_y,
	output logic signed [ACC_BITS-1:0]    accel_z
);

	localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int SUM_W = SAMPLE_BITS + 18;
	localparam int B_W   = SAMPLE_BITS + 8;
	localparam int N_W   = SUM_W + 8;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_AXES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUB,
		S_MUL,
		S_CHECK,
		S_DIV_START,
		S_DIV_WAIT,
		S_DONE
	} state_t;

	cfg_t      cfg;
	axis_ctl_t ctl;

	state_t                        state_q;
	logic [IDX_W-1:0]              idx_q;
	mode_t                         mode_q;
	mode_t                         cur_q;
	logic [CHK_BITS-1:0]           tick_q;
	logic [CHK_BITS-1:0]           settle_q;
	logic [CNT_BITS-1:0]           count_q;
	logic [DIVISOR_W-1:0]          n_q;
	logic signed [TEMP_BITS-1:0]   temp_q;
	logic signed [SAMPLE_BITS-1:0] raw_q [NUM_AXES];
	logic                          ovalid_q;
	mode_t                         phase_q;
	logic signed [CORR_BITS-1:0]   corr_o_q [MAX_AXES];
	logic signed [ACC_BITS-1:0]    acc_o_q [MAX_AXES];

	logic signed [SAMPLE_BITS-1:0] rate_in [MAX_AXES];
	logic signed [CORR_BITS-1:0]   corr_u [NUM_AXES];
	logic signed [ACC_BITS-1:0]    acc_u [NUM_AXES];
	logic signed [CORR_BITS-1:0]   corr_full [MAX_AXES];
	logic signed [ACC_BITS-1:0]    acc_full [MAX_AXES];
	logic signed [SUM_W-1:0]       sum_rd;
	logic signed [N_W-1:0]         dividend;
	logic signed [N_W-1:0]         quotient;
	logic                          div_done;

	logic [DIVISOR_W-1:0]          n_next;
	logic [DIVISOR_W-1:0]          limit;
	logic                          calib_end;
	logic signed [TEMP_BITS:0]     tdiff;
	logic [TEMP_BITS:0]            tabs;
	logic                          in_window;
	logic                          check_now;
	logic [CHK_BITS-1:0]           settle_next;
	logic [CHK_BITS-1:0]           div_eff;
	logic [CHK_BITS:0]             tick_inc;
	logic [CHK_BITS-1:0]           tick_next;
	logic                          out_free;

	assign rate_in[0] = rate_x;
	assign rate_in[1] = rate_y;
	assign rate_in[2] = rate_z;

	gwbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		ctl.sub_en  = (state_q == S_SUB);
		ctl.mul_en  = (state_q == S_MUL);
		ctl.acc_en  = (cur_q == MODE_CALIB);
		ctl.run     = (cur_q == MODE_RUN);
		ctl.bias_we = (state_q == S_DIV_WAIT) && div_done;
	end

	gwbc_axis #(
		.NUM_AXES    (NUM_AXES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_axis (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.idx         (idx_q),
		.raw         (raw_q[idx_q]),
		.sample_rate (cfg.sample_rate),
		.bias_wr     (quotient[B_W-1:0]),
		.sum_rd      (sum_rd),
		.corr        (corr_u),
		.accel       (acc_u)
	);

	assign dividend = {sum_rd, 8'd0};

	gwbc_div #(
		.N_W (N_W),
		.D_W (DIVISOR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIV_START),
		.dividend (dividend),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// missing axes read as zero
	for (genvar a = 0; a < MAX_AXES; a++) begin : g_axis_out
		if (a < NUM_AXES) begin : g_used
			assign corr_full[a] = corr_u[a];
			assign acc_full[a]  = acc_u[a];
		end else begin : g_unused
			assign corr_full[a] = '0;
			assign acc_full[a]  = '0;
		end
	end

	// end-of-item bookkeeping: calibration count and temperature check
	always_comb begin
		n_next      = {1'b0, count_q} + DIVISOR_W'(1);
		limit       = (cfg.calib_samples == '0) ? {1'b1, {CNT_BITS{1'b0}}}
			: {1'b0, cfg.calib_samples};
		calib_end   = (cur_q == MODE_CALIB) && (n_next >= limit);
		tdiff       = {temp_q[TEMP_BITS-1], temp_q}
			- {cfg.target_temp[TEMP_BITS-1], cfg.target_temp};
		tabs        = tdiff[TEMP_BITS] ? (TEMP_BITS+1)'(-tdiff) : tdiff;
		in_window   = tabs < {{(TEMP_BITS+1-WIN_BITS){1'b0}}, cfg.temp_window};
		check_now   = (cur_q == MODE_WARMUP) && (tick_q == '0);
		settle_next = settle_q + CHK_BITS'(1);
		div_eff     = (cfg.check_divider == '0) ? CHK_BITS'(1) : cfg.check_divider;
		tick_inc    = {1'b0, tick_q} + (CHK_BITS+1)'(1);
		tick_next   = (tick_inc >= {1'b0, div_eff}) ? '0 : tick_inc[CHK_BITS-1:0];
	end

	assign out_free = !ovalid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			mode_q   <= MODE_WARMUP;
			cur_q    <= MODE_WARMUP;
			tick_q   <= '0;
			settle_q <= '0;
			count_q  <= '0;
			n_q      <= '0;
			temp_q   <= '0;
			ovalid_q <= 1'b0;
			phase_q  <= MODE_WARMUP;
			for (int a = 0; a < NUM_AXES; a++)
				raw_q[a] <= '0;
			for (int a = 0; a < MAX_AXES; a++) begin
				corr_o_q[a] <= '0;
				acc_o_q[a]  <= '0;
			end
		end else begin
			if (state_q == S_DONE && out_free)
				ovalid_q <= 1'b1;
			else if (!result_stall)
				ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						for (int a = 0; a < NUM_AXES; a++)
							raw_q[a] <= rate_in[a];
						temp_q  <= temperature;
						cur_q   <= mode_q;
						idx_q   <= '0;
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_CHECK;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_SUB;
					end
				end
				S_CHECK: begin
					tick_q <= tick_next;
					if (cur_q == MODE_CALIB)
						count_q <= n_next[CNT_BITS-1:0];
					if (calib_end) begin
						n_q     <= n_next;
						mode_q  <= MODE_RUN;
						idx_q   <= '0;
						state_q <= S_DIV_START;
					end else begin
						state_q <= S_DONE;
					end
					if (check_now && in_window) begin
						settle_q <= settle_next;
						if (settle_next >= cfg.settle_checks)
							mode_q <= MODE_CALIB;
					end
				end
				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						if (idx_q == LAST_IDX) begin
							state_q <= S_DONE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_DIV_START;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						phase_q <= cur_q;
						for (int a = 0; a < MAX_AXES; a++) begin
							corr_o_q[a] <= corr_full[a];
							acc_o_q[a]  <= acc_full[a];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_stall = (state_q != S_IDLE);
	assign result_valid = ovalid_q;
	assign phase        = phase_q;
	assign ready_res    = (phase_q == MODE_RUN);
	assign corr_x       = corr_o_q[0];
	assign corr_y       = corr_o_q[1];
	assign corr_z       = corr_o_q[2];
	assign accel_x      = acc_o_q[0];
	assign accel_y      = acc_o_q[1];
	assign accel_z      = acc_o_q[2];

endmodule

// ===== design/gwbc_checker.sv =====
// Port-level assertions for the gyro warm-up bias calibrator, bound to the top level.
module gwbc_checker import gwbc_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        sample_valid,
	input logic                        sample_stall,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [1:0]                  phase,
	input logic                        ready_res,
	input logic signed [CORR_BITS-1:0] corr_x,
	input logic signed [CORR_BITS-1:0] corr_y,
	input logic signed [CORR_BITS-1:0] corr_z,
	input logic signed [ACC_BITS-1:0]  accel_x,
	input logic signed [ACC_BITS-1:0]  accel_y,
	input logic signed [ACC_BITS-1:0]  accel_z
);

	// ready flag tracks the running phase
	a_ready_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (ready_res == (phase == MODE_RUN)))
		else $error("ready_res disagrees with phase");

	// a sample transfer starts multi-cycle work
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("input not stalled after sample transfer");

	// before running: no acceleration and rates are raw samples scaled by 256
	a_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (phase != MODE_RUN)) |->
			(accel_x == '0 && accel_y == '0 && accel_z == '0 &&
			corr_x[7:0] == 8'd0 && corr_y[7:0] == 8'd0 && corr_z[7:0] == 8'd0))
		else $error("non-running result carries bias or acceleration");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(corr_x) && $stable(accel_x) && $stable(phase)))
		else $error("stalled result changed");

endmodule

bind gyro_warmup_bias_calibrator gwbc_checker u_gwbc_checker (.*);
